@@ rtl/lafl_pkg.sv @@
// lafl_pkg: shared types, codes and coefficient tables of the fir low-pass block
// no dependencies
`default_nettype none
package lafl_pkg;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAME_BITS  = 16;
   localparam int CNT_BITS    = 17;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 17;
   localparam int ACC_BITS = 48;

   localparam logic [CSR_ADDR_BITS-1:0] REG_FILTER_MODE   = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CHANNEL_COUNT = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_FRAME_COUNT   = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_LOOP_ENABLE   = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_LOOP_START    = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] REG_LOOP_LENGTH   = 3'd5;

   localparam logic [1:0] MODE_FIRST  = 2'd1;
   localparam logic [1:0] MODE_SECOND = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // command kinds handed from front to back
   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_OOR   = 2'd1,
      CMD_PASS  = 2'd2,
      CMD_FIR   = 2'd3
   } cmd_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_TAP   = 3'd1,
      ST_DRAIN = 3'd2,
      ST_ROUND = 3'd3,
      ST_OUT   = 3'd4
   } back_state_type;

   // 32-bit coefficient from table and tap
   function automatic logic signed [31:0] coef(input logic second, input logic [5:0] d);
      logic signed [31:0] a [0:30];
      logic signed [31:0] b [0:30];
      begin
         a = '{4451951, 3496322, 413266, 43034, -26954, 20100, -15385, 12107,
               -9762, 8037, -6732, 5722, -4925, 4285, -3762, 3331,
               -2970, 2666, -2406, 2183, -1989, 1821, -1673, 1543,
               -1427, 1324, -1232, 1149, -1075, 1007, -946};
         b = '{5017996, 3179995, 155908, 58284, -39063, 27751, -20619, 15906,
               -12644, 10296, -8550, 7217, -6175, 5345, -4674, 4122,
               -3663, 3278, -2950, 2670, -2428, 2218, -2034, 1873,
               -1729, 1602, -1489, 1387, -1295, 1212, -1137};
         if (d > 6'd30) coef = '0;
         else if (second) coef = b[d[4:0]];
         else coef = a[d[4:0]];
      end
   endfunction
endpackage
`default_nettype wire

@@ rtl/lafl_if.sv @@
// lafl_if: valid/ready channel interfaces for requests, responses and csr writes
// depends on lafl_pkg
`default_nettype none
interface lafl_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic [lafl_pkg::FRAME_BITS-1:0] frame_index;
   logic channel;
   logic signed [lafl_pkg::SAMPLE_BITS-1:0] sample_value;
   modport source (output valid, operation, frame_index, channel, sample_value, input ready);
   modport sink (input valid, operation, frame_index, channel, sample_value, output ready);
endinterface

interface lafl_rsp_if;
   logic valid;
   logic ready;
   logic signed [lafl_pkg::SAMPLE_BITS-1:0] filtered_value;
   logic out_of_range;
   modport source (output valid, filtered_value, out_of_range, input ready);
   modport sink (input valid, filtered_value, out_of_range, output ready);
endinterface

interface lafl_csr_if;
   logic valid;
   logic ready;
   logic [lafl_pkg::CSR_ADDR_BITS-1:0] index;
   logic [lafl_pkg::CSR_DATA_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/lafl_front.sv @@
// lafl_front: accepts requests, classifies them and computes loop bounds
// depends on lafl_pkg
`default_nettype none
module lafl_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic in_ready,
   input  wire logic operation,
   input  wire logic [lafl_pkg::FRAME_BITS-1:0] frame_index,
   input  wire logic channel,
   input  wire logic signed [15:0] sample_value,
   input  wire logic [1:0] filter_mode,
   input  wire logic [1:0] channel_count,
   input  wire logic [16:0] frames,
   input  wire logic loop_enable,
   input  wire logic [16:0] loop_start,
   input  wire logic [16:0] loop_length,
   output logic cmd_valid,
   input  wire logic cmd_ready,
   output lafl_pkg::cmd_kind_type cmd_kind,
   output logic [15:0] cmd_frame,
   output logic cmd_channel,
   output logic signed [15:0] cmd_sample,
   output logic cmd_second,
   output logic cmd_in_loop,
   output logic [16:0] cmd_begin,
   output logic [16:0] cmd_len
);
   logic [1:0] chans;
   logic [16:0] fr17, lbegin, rest, llen;
   logic inl;
   lafl_pkg::cmd_kind_type kind;

   // effective counts and loop window
   always_comb begin
      chans = (channel_count == 2'd0) ? 2'd1 : ((channel_count > 2'd2) ? 2'd2 : channel_count);
      fr17 = (frames > 17'h10000) ? 17'h10000 : frames;
      lbegin = (loop_start < fr17) ? loop_start : fr17;
      rest = fr17 - lbegin;
      llen = '0;
      if (loop_enable && lbegin < fr17)
         llen = (loop_length == 17'd0) ? rest : ((loop_length < rest) ? loop_length : rest);
      inl = (llen != 17'd0) && ({1'b0, frame_index} >= lbegin)
            && ({1'b0, frame_index} < lbegin + llen);
      if (operation == lafl_pkg::OP_LOAD) kind = lafl_pkg::CMD_LOAD;
      else if ({1'b0, frame_index} >= fr17 || {1'b0, channel} >= chans) kind = lafl_pkg::CMD_OOR;
      else if (filter_mode == lafl_pkg::MODE_FIRST || filter_mode == lafl_pkg::MODE_SECOND)
         kind = lafl_pkg::CMD_FIR;
      else kind = lafl_pkg::CMD_PASS;
   end

   // one-entry queue register
   logic full_ff;
   assign in_ready = !full_ff || cmd_ready;
   assign cmd_valid = full_ff;
   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else if (in_ready) full_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         cmd_kind <= kind;
         cmd_frame <= frame_index;
         cmd_channel <= channel;
         cmd_sample <= sample_value;
         cmd_second <= (filter_mode == lafl_pkg::MODE_SECOND);
         cmd_in_loop <= inl;
         cmd_begin <= lbegin;
         cmd_len <= llen;
      end
   end
endmodule
`default_nettype wire

@@ rtl/lafl_back.sv @@
// lafl_back: sample store, tap sequencer, mac and rounding
// depends on lafl_pkg
`default_nettype none
module lafl_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cmd_valid,
   output logic cmd_ready,
   input  wire lafl_pkg::cmd_kind_type cmd_kind,
   input  wire logic [15:0] cmd_frame,
   input  wire logic cmd_channel,
   input  wire logic signed [15:0] cmd_sample,
   input  wire logic cmd_second,
   input  wire logic cmd_in_loop,
   input  wire logic [16:0] cmd_begin,
   input  wire logic [16:0] cmd_len,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic signed [15:0] rsp_value,
   output logic rsp_oor
);
   logic signed [15:0] mem [0:131071];
   lafl_pkg::back_state_type state_ff, state_in;
   logic [5:0] d_ff, d_in;
   logic ch_ff, second_ff, inl_ff;
   logic [16:0] begin_ff, len_ff;
   logic [16:0] off_ff, off_in;     // loop offset of current tap
   logic [16:0] src_ff, src_in;
   logic signed [15:0] rd_ff;
   logic rd_vld_ff;
   logic signed [47:0] acc_ff;
   logic signed [15:0] out_ff;
   logic oor_ff, ovld_ff;
   logic take, rd_en, last_tap;

   assign cmd_ready = (state_ff == lafl_pkg::ST_IDLE) && !ovld_ff;
   assign take = cmd_valid && cmd_ready;
   assign last_tap = (d_ff == 6'd30);
   assign rsp_valid = ovld_ff;
   assign rsp_value = out_ff;
   assign rsp_oor = oor_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lafl_pkg::ST_IDLE:
            if (take && cmd_kind == lafl_pkg::CMD_FIR) state_in = lafl_pkg::ST_TAP;
            else if (take && cmd_kind != lafl_pkg::CMD_LOAD) state_in = lafl_pkg::ST_OUT;
         lafl_pkg::ST_TAP:   if (last_tap) state_in = lafl_pkg::ST_DRAIN;
         lafl_pkg::ST_DRAIN: state_in = lafl_pkg::ST_ROUND;
         lafl_pkg::ST_ROUND: state_in = lafl_pkg::ST_IDLE;
         lafl_pkg::ST_OUT:   state_in = lafl_pkg::ST_IDLE;
         default: state_in = lafl_pkg::ST_IDLE;
      endcase
   end

   // tap address walk: offset steps back by one, wrapping inside the loop
   always_comb begin
      d_in = d_ff;
      off_in = off_ff;
      src_in = src_ff;
      rd_en = 1'b0;
      case (state_ff)
         lafl_pkg::ST_IDLE: begin
            d_in = '0;
            off_in = {1'b0, cmd_frame} - cmd_begin;
            src_in = {1'b0, cmd_frame};
            rd_en = take && (cmd_kind == lafl_pkg::CMD_PASS || cmd_kind == lafl_pkg::CMD_FIR);
         end
         lafl_pkg::ST_TAP: begin
            d_in = d_ff + 6'd1;
            off_in = (off_ff == 17'd0) ? len_ff - 17'd1 : off_ff - 17'd1;
            if (inl_ff) src_in = begin_ff + off_in;
            else src_in = (src_ff == 17'd0) ? 17'd0 : src_ff - 17'd1;
            rd_en = !last_tap;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= lafl_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   // single-port store: load write or tap read
   always_ff @(posedge clock) begin
      if (take && cmd_kind == lafl_pkg::CMD_LOAD) mem[{cmd_frame, cmd_channel}] <= cmd_sample;
      else if (rd_en) rd_ff <= mem[{src_in[15:0], (state_ff == lafl_pkg::ST_IDLE) ? cmd_channel : ch_ff}];
   end

   always_ff @(posedge clock) begin
      if (reset) rd_vld_ff <= 1'b0;
      else rd_vld_ff <= rd_en && !(state_ff == lafl_pkg::ST_IDLE && cmd_kind == lafl_pkg::CMD_PASS);
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
      off_ff <= off_in;
      src_ff <= src_in;
      if (take) begin
         ch_ff <= cmd_channel;
         second_ff <= cmd_second;
         inl_ff <= cmd_in_loop;
         begin_ff <= cmd_begin;
         len_ff <= cmd_len;
      end
   end

   // multiply-accumulate on fetched taps: in the tap state rd_ff holds tap d_ff
   logic signed [31:0] coef_w;
   logic signed [47:0] prod;
   assign coef_w = lafl_pkg::coef(second_ff, d_ff);
   assign prod = 48'(rd_ff) * 48'(coef_w);
   always_ff @(posedge clock) begin
      if (state_ff == lafl_pkg::ST_IDLE) acc_ff <= '0;
      else if (rd_vld_ff) acc_ff <= acc_ff + prod;
   end

   // round half away, saturate
   logic neg;
   logic [47:0] mag;
   logic signed [16:0] res;
   always_comb begin
      neg = acc_ff[47];
      mag = neg ? 48'(-acc_ff) : 48'(acc_ff);
      mag = (mag + 48'h400000) >> 23;
      if (mag > 48'd32768) mag = 48'd32768;
      res = neg ? -17'(mag) : 17'(mag);
      if (res > 17'sd32767) res = 17'sd32767;
   end

   always_ff @(posedge clock) begin
      if (reset) ovld_ff <= 1'b0;
      else if (state_ff == lafl_pkg::ST_ROUND || state_ff == lafl_pkg::ST_OUT) ovld_ff <= 1'b1;
      else if (rsp_ready) ovld_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (take) oor_ff <= (cmd_kind == lafl_pkg::CMD_OOR);
      if (state_ff == lafl_pkg::ST_ROUND) out_ff <= res[15:0];
      else if (state_ff == lafl_pkg::ST_OUT) out_ff <= oor_ff ? 16'sd0 : rd_ff;
   end
endmodule
`default_nettype wire

@@ rtl/loop_aware_fir_lowpass.sv @@
// loop_aware_fir_lowpass: top level, csr registers, front and back parts
// depends on lafl_pkg, lafl_if, lafl_front, lafl_back
//
// channel  dir  handshake           payload
// req      in   valid/ready         operation, frame_index, channel, sample_value
// rsp      out  valid/ready         filtered_value, out_of_range
// csr      in   valid/ready         index, data
//
// a filtered read passes the queue register, then 31 tap reads through the single
// store port, then the drain and round states before its response shows.
// the back part takes its next command in the cycle after the response transfer,
// so it takes no new command while a response waits. pass and out-of-range
// reads pass the queue register and the out state; loads give no response.
// reset is synchronous; the store is not cleared. a one-entry queue between
// front and back lets the front take the next request while back works.
`default_nettype none
module loop_aware_fir_lowpass (
   input wire logic clock,
   input wire logic reset,
   lafl_req_if.sink req,
   lafl_rsp_if.source rsp,
   lafl_csr_if.sink csr
);
   logic [1:0] mode_ff, chan_ff;
   logic [16:0] frames_ff, lstart_ff, llen_ff;
   logic len_ff;

   assign csr.ready = 1'b1;
   // csr write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd0; chan_ff <= 2'd1; frames_ff <= '0;
         len_ff <= 1'b0; lstart_ff <= '0; llen_ff <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            lafl_pkg::REG_FILTER_MODE:   mode_ff <= csr.data[1:0];
            lafl_pkg::REG_CHANNEL_COUNT: chan_ff <= csr.data[1:0];
            lafl_pkg::REG_FRAME_COUNT:   frames_ff <= csr.data;
            lafl_pkg::REG_LOOP_ENABLE:   len_ff <= csr.data[0];
            lafl_pkg::REG_LOOP_START:    lstart_ff <= csr.data;
            lafl_pkg::REG_LOOP_LENGTH:   llen_ff <= csr.data;
            default: ;
         endcase
      end
   end

   logic cv, cr, csec, cinl, cch;
   lafl_pkg::cmd_kind_type ck;
   logic [15:0] cf;
   logic signed [15:0] cs;
   logic [16:0] cb, cl;

   lafl_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .operation(req.operation),
      .frame_index(req.frame_index), .channel(req.channel), .sample_value(req.sample_value),
      .filter_mode(mode_ff), .channel_count(chan_ff), .frames(frames_ff),
      .loop_enable(len_ff), .loop_start(lstart_ff), .loop_length(llen_ff),
      .cmd_valid(cv), .cmd_ready(cr), .cmd_kind(ck), .cmd_frame(cf), .cmd_channel(cch),
      .cmd_sample(cs), .cmd_second(csec), .cmd_in_loop(cinl), .cmd_begin(cb), .cmd_len(cl)
   );

   lafl_back u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cv), .cmd_ready(cr), .cmd_kind(ck), .cmd_frame(cf), .cmd_channel(cch),
      .cmd_sample(cs), .cmd_second(csec), .cmd_in_loop(cinl), .cmd_begin(cb), .cmd_len(cl),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_value(rsp.filtered_value),
      .rsp_oor(rsp.out_of_range)
   );
endmodule
`default_nettype wire
